// File: rtl/core/ust_pkg.sv
// Shared types, event codes and state codes for the datagram session tracker.
package ust_pkg;

   // Event kinds carried in the request word.
   localparam logic [1:0] KIND_LISTEN   = 2'd0;
   localparam logic [1:0] KIND_CONNECT  = 2'd1;
   localparam logic [1:0] KIND_DATAGRAM = 2'd2;
   localparam logic [1:0] KIND_TICK     = 2'd3;

   // Session states.
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_LISTENING  = 3'd1;
   localparam logic [2:0] ST_CONNECTING = 3'd2;
   localparam logic [2:0] ST_CONNECTED  = 3'd3;
   localparam logic [2:0] ST_TIMED_OUT  = 3'd4;

   // Session modes.
   localparam logic [1:0] MD_NONE   = 2'd0;
   localparam logic [1:0] MD_SERVER = 2'd1;
   localparam logic [1:0] MD_CLIENT = 2'd2;

   // Idle time is kept in 17 bits and saturates at its maximum.
   localparam int unsigned IDLE_W = 17;
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   // Timeout limit after reset.
   localparam logic [15:0] LIMIT_RESET = 16'd1000;

   // One request word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [15:0] elapsed;
   } event_type;

   // One result word.
   typedef struct packed {
      logic [2:0] session_state;
      logic [1:0] session_mode;
      logic       accepted;
      logic       connect_event;
      logic       disconnect_event;
   } result_type;

endpackage

// File: rtl/core/ust_input_stage.sv
// Input register that captures one request word and holds it until the core takes it.
module ust_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ust_pkg::event_type req_word,
   input  logic               take,
   output logic               word_valid,
   output ust_pkg::event_type word
);

   logic               valid_ff;
   logic               valid_in;
   ust_pkg::event_type word_ff;
   logic               load;

   // The register can load when empty or when its word moves on this cycle.
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// File: rtl/core/ust_session_core.sv
// Session state registers, timeout limit and next-state logic for one event.
module ust_session_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                fire,
   input  ust_pkg::event_type  word,
   output ust_pkg::result_type result
);

   logic [15:0]                 limit_ff;
   logic [2:0]                  state_ff, state_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [31:0]                 raddr_ff, raddr_in;
   logic [15:0]                 rport_ff, rport_in;
   logic [ust_pkg::IDLE_W-1:0]  idle_ff, idle_in;
   logic [ust_pkg::IDLE_W:0]    sum;
   logic [ust_pkg::IDLE_W-1:0]  sat;
   logic                        server_listen;
   logic                        peer_match;
   logic                        acc, conn_ev, disc_ev;

   // Saturating idle time for a tick.
   assign sum = {1'b0, idle_ff} + {{(ust_pkg::IDLE_W + 1 - 16){1'b0}}, word.elapsed};
   assign sat = sum[ust_pkg::IDLE_W] ? ust_pkg::IDLE_MAX : sum[ust_pkg::IDLE_W-1:0];

   // A listening server adopts the sender, so the sender then matches the peer.
   assign server_listen = (mode_ff == ust_pkg::MD_SERVER) &&
                          (state_ff == ust_pkg::ST_LISTENING);
   assign peer_match    = server_listen ||
                          ((word.peer_address == raddr_ff) && (word.peer_port == rport_ff));

   // Next session state and event flags.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      raddr_in = raddr_ff;
      rport_in = rport_ff;
      idle_in  = idle_ff;
      acc      = 1'b0;
      conn_ev  = 1'b0;
      disc_ev  = 1'b0;
      case (word.kind)
         ust_pkg::KIND_LISTEN: begin
            disc_ev  = (state_ff == ust_pkg::ST_CONNECTED);
            state_in = ust_pkg::ST_LISTENING;
            mode_in  = ust_pkg::MD_SERVER;
            raddr_in = '0;
            rport_in = '0;
            idle_in  = '0;
         end
         ust_pkg::KIND_CONNECT: begin
            disc_ev  = (state_ff == ust_pkg::ST_CONNECTED);
            state_in = ust_pkg::ST_CONNECTING;
            mode_in  = ust_pkg::MD_CLIENT;
            raddr_in = word.peer_address;
            rport_in = word.peer_port;
            idle_in  = '0;
         end
         ust_pkg::KIND_DATAGRAM: begin
            if (server_listen) begin
               state_in = ust_pkg::ST_CONNECTED;
               raddr_in = word.peer_address;
               rport_in = word.peer_port;
               conn_ev  = 1'b1;
            end
            if (peer_match) begin
               if ((mode_ff == ust_pkg::MD_CLIENT) &&
                   (state_ff == ust_pkg::ST_CONNECTING)) begin
                  state_in = ust_pkg::ST_CONNECTED;
                  conn_ev  = 1'b1;
               end
               idle_in = '0;
               acc     = 1'b1;
            end
         end
         ust_pkg::KIND_TICK: begin
            if (raddr_ff != '0) begin
               if (limit_ff == '0) begin
                  idle_in = '0;
               end else begin
                  idle_in = sat;
                  if ((sat > {{(ust_pkg::IDLE_W - 16){1'b0}}, limit_ff}) &&
                      ((state_ff == ust_pkg::ST_CONNECTING) ||
                       (state_ff == ust_pkg::ST_CONNECTED))) begin
                     state_in = ust_pkg::ST_TIMED_OUT;
                     mode_in  = ust_pkg::MD_NONE;
                     raddr_in = '0;
                     rport_in = '0;
                     idle_in  = '0;
                     disc_ev  = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // Timeout limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ust_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Session registers advance once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ust_pkg::ST_IDLE;
         mode_ff  <= ust_pkg::MD_NONE;
         raddr_ff <= '0;
         rport_ff <= '0;
         idle_ff  <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         raddr_ff <= raddr_in;
         rport_ff <= rport_in;
         idle_ff  <= idle_in;
      end
   end

   assign result.session_state    = state_in;
   assign result.session_mode     = mode_in;
   assign result.accepted         = acc;
   assign result.connect_event    = conn_ev;
   assign result.disconnect_event = disc_ev;

endmodule

// File: rtl/core/ust_result_reg.sv
// Result register that holds one result word until the consumer takes it.
module ust_result_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ust_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ust_pkg::result_type rsp_word
);

   logic                valid_ff;
   logic                valid_in;
   ust_pkg::result_type word_ff;

   // The register is free when empty or when its word is taken this cycle.
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (free ? 1'b0 : valid_ff);

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: rtl/core/udp_session_tracker_unit.sv
// Top level of the datagram session tracker: input register, session core, result register.
// A word accepted into the input register is processed once the result register can take its
// result; that result is registered in the result register and offered on the result channel.
// Throughput: one word per cycle while the result channel does not stall, with the session
// update between the input register and the result register being combinational.
// Reset (synchronous, active high) empties both registers, sets the session to idle with
// no peer and zero idle time, and loads a timeout limit of 1000.
module udp_session_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_peer_address,
   input  logic [15:0] req_peer_port,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_session_state,
   output logic [1:0]  rsp_session_mode,
   output logic        rsp_accepted,
   output logic        rsp_connect_event,
   output logic        rsp_disconnect_event
);

   ust_pkg::event_type  req_word;
   ust_pkg::event_type  word;
   ust_pkg::result_type result;
   ust_pkg::result_type rsp_word;
   logic                word_valid;
   logic                free;
   logic                fire;

   // Gather the request fields into one word.
   assign req_word.kind         = req_kind;
   assign req_word.peer_address = req_peer_address;
   assign req_word.peer_port    = req_peer_port;
   assign req_word.elapsed      = req_elapsed;

   // A held word is processed when the result register can take its result.
   assign fire = word_valid && free;

   ust_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .take       (fire),
      .word_valid (word_valid),
      .word       (word)
   );

   ust_session_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .word             (word),
      .result           (result)
   );

   ust_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Split the result word onto its ports.
   assign rsp_session_state    = rsp_word.session_state;
   assign rsp_session_mode     = rsp_word.session_mode;
   assign rsp_accepted         = rsp_word.accepted;
   assign rsp_connect_event    = rsp_word.connect_event;
   assign rsp_disconnect_event = rsp_word.disconnect_event;

endmodule

// File: tb/sv/udp_session_tracker_unit_tb.sv
// Self-checking testbench for the datagram session tracker: directed table, random phases.
`timescale 1ns / 1ps

module udp_session_tracker_unit_tb;

   // One row of the directed table; typed rows carry their result, the others use the predictor.
   typedef struct {
      ust_pkg::event_type  ev;
      bit                  typed;
      ust_pkg::result_type res;
   } event_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = ust_pkg::KIND_LISTEN;
   logic [31:0] req_peer_address = '0;
   logic [15:0] req_peer_port = '0;
   logic [15:0] req_elapsed = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_session_state;
   logic [1:0]  rsp_session_mode;
   logic        rsp_accepted;
   logic        rsp_connect_event;
   logic        rsp_disconnect_event;

   // Session state as the predictor sees it.
   logic [15:0]                limit_setting = ust_pkg::LIMIT_RESET;
   logic [2:0]                 sess_state = ust_pkg::ST_IDLE;
   logic [1:0]                 sess_mode = ust_pkg::MD_NONE;
   logic [31:0]                peer_addr = '0;
   logic [15:0]                peer_port_q = '0;
   logic [ust_pkg::IDLE_W-1:0] idle_ticks = '0;

   ust_pkg::result_type expected_results[$];
   event_row_type       directed_events[$];
   logic [31:0]         pool_addr[4];
   logic [15:0]         pool_port[4];
   int                  error_count = 0;
   int                  burst_left = 0;
   int                  items_sent = 0;

   udp_session_tracker_unit dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_peer_address     (req_peer_address),
      .req_peer_port        (req_peer_port),
      .req_elapsed          (req_elapsed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_session_state    (rsp_session_state),
      .rsp_session_mode     (rsp_session_mode),
      .rsp_accepted         (rsp_accepted),
      .rsp_connect_event    (rsp_connect_event),
      .rsp_disconnect_event (rsp_disconnect_event)
   );

   // A 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Forgets the peer and returns the session to idle.
   function automatic void clear_session_state();
      idle_ticks  = '0;
      sess_state  = ust_pkg::ST_IDLE;
      sess_mode   = ust_pkg::MD_NONE;
      peer_addr   = '0;
      peer_port_q = '0;
   endfunction

   // Applies one event to the predicted session and returns the result word it should give.
   function automatic ust_pkg::result_type advance_session(ust_pkg::event_type ev);
      ust_pkg::result_type      r;
      logic [ust_pkg::IDLE_W:0] sum;
      r = '0;
      case (ev.kind)
         ust_pkg::KIND_LISTEN: begin
            r.disconnect_event = (sess_state == ust_pkg::ST_CONNECTED);
            clear_session_state();
            sess_mode  = ust_pkg::MD_SERVER;
            sess_state = ust_pkg::ST_LISTENING;
         end
         ust_pkg::KIND_CONNECT: begin
            r.disconnect_event = (sess_state == ust_pkg::ST_CONNECTED);
            clear_session_state();
            sess_mode   = ust_pkg::MD_CLIENT;
            sess_state  = ust_pkg::ST_CONNECTING;
            peer_addr   = ev.peer_address;
            peer_port_q = ev.peer_port;
         end
         ust_pkg::KIND_DATAGRAM: begin
            // A listening server takes the first sender as its peer.
            if (sess_mode == ust_pkg::MD_SERVER && sess_state == ust_pkg::ST_LISTENING) begin
               sess_state  = ust_pkg::ST_CONNECTED;
               peer_addr   = ev.peer_address;
               peer_port_q = ev.peer_port;
               r.connect_event = 1'b1;
            end
            if (ev.peer_address == peer_addr && ev.peer_port == peer_port_q) begin
               if (sess_mode == ust_pkg::MD_CLIENT &&
                   sess_state == ust_pkg::ST_CONNECTING) begin
                  sess_state = ust_pkg::ST_CONNECTED;
                  r.connect_event = 1'b1;
               end
               idle_ticks = '0;
               r.accepted = 1'b1;
            end
         end
         default: begin
            // Ticks only count once there is a peer address.
            if (peer_addr != '0) begin
               if (limit_setting == '0) begin
                  idle_ticks = '0;
               end else begin
                  sum = idle_ticks + ev.elapsed;
                  idle_ticks = (sum > ust_pkg::IDLE_MAX) ? ust_pkg::IDLE_MAX
                                                         : sum[ust_pkg::IDLE_W-1:0];
                  if (idle_ticks > limit_setting &&
                      (sess_state == ust_pkg::ST_CONNECTING ||
                       sess_state == ust_pkg::ST_CONNECTED)) begin
                     clear_session_state();
                     sess_state = ust_pkg::ST_TIMED_OUT;
                     r.disconnect_event = 1'b1;
                  end
               end
            end
         end
      endcase
      r.session_state = sess_state;
      r.session_mode  = sess_mode;
      return r;
   endfunction

   function automatic event_row_type ev_row(logic [1:0] k, logic [31:0] a, logic [15:0] p,
                                            logic [15:0] e);
      event_row_type row;
      row.ev.kind         = k;
      row.ev.peer_address = a;
      row.ev.peer_port    = p;
      row.ev.elapsed      = e;
      row.typed           = 1'b0;
      row.res             = '0;
      return row;
   endfunction

   // Flags are ordered accepted, connect, disconnect.
   function automatic event_row_type known_row(logic [1:0] k, logic [31:0] a,
                                               logic [15:0] p, logic [15:0] e,
                                               logic [2:0] st, logic [1:0] md,
                                               logic [2:0] flags);
      event_row_type row;
      row = ev_row(k, a, p, e);
      row.typed = 1'b1;
      row.res   = {st, md, flags};
      return row;
   endfunction

   // Random event: mostly endpoints from a small pool so that sessions really form.
   function automatic ust_pkg::event_type make_random_event();
      ust_pkg::event_type ev;
      int                 lim;
      int                 near;
      int                 pick;
      int                 sel;
      lim  = limit_setting;
      pick = $urandom_range(0, 19);
      if (pick < 2)
         ev.kind = ust_pkg::KIND_LISTEN;
      else if (pick < 5)
         ev.kind = ust_pkg::KIND_CONNECT;
      else if (pick < 13)
         ev.kind = ust_pkg::KIND_DATAGRAM;
      else
         ev.kind = ust_pkg::KIND_TICK;
      ev.peer_address = $urandom;
      ev.peer_port    = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (ev.kind == ust_pkg::KIND_DATAGRAM) begin
         if (sel < 6) begin
            pick = $urandom_range(0, 3);
            ev.peer_address = pool_addr[pick];
            ev.peer_port    = pool_port[pick];
         end else if (sel < 8) begin
            ev.peer_address = peer_addr;
            ev.peer_port    = peer_port_q;
         end else if (sel == 8) begin
            ev.peer_address = '0;
            ev.peer_port    = '0;
         end
      end else if (ev.kind == ust_pkg::KIND_CONNECT) begin
         if (sel < 8) begin
            pick = $urandom_range(0, 3);
            ev.peer_address = pool_addr[pick];
            ev.peer_port    = pool_port[pick];
         end else if (sel == 8) begin
            ev.peer_address = '0;
         end
      end
      // Elapsed time is spread around the current limit.
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ev.elapsed = 16'($urandom_range(0, lim / 4 + 2));
         4, 5: begin
            near = lim - 1 + $urandom_range(0, 2);
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            ev.elapsed = near[15:0];
         end
         6: ev.elapsed = '0;
         7: ev.elapsed = 16'hFFFF;
         default: ev.elapsed = 16'($urandom_range(0, 65535));
      endcase
      return ev;
   endfunction

   // Offers one word in bursts with random gaps, then records its expected result.
   task automatic send_event(ust_pkg::event_type ev, bit typed,
                             ust_pkg::result_type typed_res);
      ust_pkg::result_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_valid        <= 1'b1;
      req_kind         <= ev.kind;
      req_peer_address <= ev.peer_address;
      req_peer_port    <= ev.peer_port;
      req_elapsed      <= ev.elapsed;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
      r = advance_session(ev);
      if (typed)
         r = typed_res;
      expected_results.push_back(r);
   endtask

   // Writes the limit once every result is out and the pipeline has drained.
   task automatic set_timeout_limit(logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_setting = value;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      ust_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result word with no expectation waiting");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("session_state", want.session_state, rsp_session_state);
            check_field("session_mode", want.session_mode, rsp_session_mode);
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("connect_event", want.connect_event, rsp_connect_event);
            check_field("disconnect_event", want.disconnect_event, rsp_disconnect_event);
         end
      end
   end

   // Receiver stalls in patterns of its own, with one long hold-off to fill the block.
   initial begin
      int stretch;
      int mode_sel;
      bit held_long;
      held_long = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!held_long && items_sent > 200) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            mode_sel = $urandom_range(0, 9);
            stretch  = $urandom_range(4, 64);
            for (int k = 0; k < stretch; k++) begin
               case (mode_sel)
                  0, 1, 2, 3: rsp_stall <= 1'b0;
                  4, 5, 6: rsp_stall <= ($urandom_range(0, 99) < 40);
                  7, 8: rsp_stall <= (k % 3 == 2);
                  default: rsp_stall <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < 3000) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("udp_session_tracker_unit_tb: done, errors");
      $finish;
   end

   // Main sequence: directed table at the reset limit, then random phases over several limits.
   initial begin
      ust_pkg::event_type ev;
      logic [15:0]        next_limit;

      // Empty session, listening server, peer adoption and idle counting.
      directed_events.push_back(known_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'hFFFF,
                                          ust_pkg::ST_IDLE, ust_pkg::MD_NONE, 3'b000));
      directed_events.push_back(known_row(ust_pkg::KIND_DATAGRAM, 32'h0, 16'h0, 16'h0,
                                          ust_pkg::ST_IDLE, ust_pkg::MD_NONE, 3'b100));
      directed_events.push_back(known_row(ust_pkg::KIND_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF,
                                          16'h0, ust_pkg::ST_IDLE, ust_pkg::MD_NONE,
                                          3'b000));
      directed_events.push_back(known_row(ust_pkg::KIND_LISTEN, 32'hFFFF_FFFF, 16'hFFFF,
                                          16'hFFFF, ust_pkg::ST_LISTENING,
                                          ust_pkg::MD_SERVER, 3'b000));
      directed_events.push_back(known_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'hFFFF,
                                          ust_pkg::ST_LISTENING, ust_pkg::MD_SERVER,
                                          3'b000));
      directed_events.push_back(known_row(ust_pkg::KIND_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF,
                                          16'h0, ust_pkg::ST_CONNECTED,
                                          ust_pkg::MD_SERVER, 3'b110));
      directed_events.push_back(ev_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'd500));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'h0102_0304, 16'h0102,
                                       16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF,
                                       16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'd1000));
      // One tick past the limit times out a connected session.
      directed_events.push_back(known_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'd1,
                                          ust_pkg::ST_TIMED_OUT, ust_pkg::MD_NONE,
                                          3'b001));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'h0, 16'h0, 16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'hFFFF));
      // Client side: wrong sender, timeout while connecting, then a real connection.
      directed_events.push_back(ev_row(ust_pkg::KIND_CONNECT, 32'h0A00_0001, 16'd53,
                                       16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'h0A00_0001, 16'd54,
                                       16'h0));
      directed_events.push_back(known_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'hFFFF,
                                          ust_pkg::ST_TIMED_OUT, ust_pkg::MD_NONE,
                                          3'b001));
      directed_events.push_back(known_row(ust_pkg::KIND_CONNECT, 32'hFFFF_FFFF, 16'hFFFF,
                                          16'hFFFF, ust_pkg::ST_CONNECTING,
                                          ust_pkg::MD_CLIENT, 3'b000));
      directed_events.push_back(known_row(ust_pkg::KIND_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF,
                                          16'h0, ust_pkg::ST_CONNECTED,
                                          ust_pkg::MD_CLIENT, 3'b110));
      directed_events.push_back(known_row(ust_pkg::KIND_LISTEN, 32'h0, 16'h0, 16'h0,
                                          ust_pkg::ST_LISTENING, ust_pkg::MD_SERVER,
                                          3'b001));
      directed_events.push_back(ev_row(ust_pkg::KIND_LISTEN, 32'h5555_5555, 16'h5555,
                                       16'h5555));
      // Connecting to address zero leaves ticks with no effect.
      directed_events.push_back(ev_row(ust_pkg::KIND_CONNECT, 32'h0, 16'h1234, 16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_TICK, 32'h0, 16'h0, 16'hFFFF));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'h0, 16'h1234, 16'h0));
      directed_events.push_back(ev_row(ust_pkg::KIND_CONNECT, 32'h55AA_55AA, 16'hAAAA,
                                       16'hAAAA));
      directed_events.push_back(ev_row(ust_pkg::KIND_DATAGRAM, 32'hAA55_AA55, 16'h5555,
                                       16'h0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_events[i])
         send_event(directed_events[i].ev, directed_events[i].typed, directed_events[i].res);

      // Random phases, each with its own limit and endpoint pool.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: next_limit = 16'd0;
            1: next_limit = 16'hFFFF;
            2: next_limit = 16'd1;
            3: next_limit = 16'($urandom_range(2, 300));
            default: next_limit = ust_pkg::LIMIT_RESET;
         endcase
         set_timeout_limit(next_limit);
         for (int i = 0; i < 4; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom_range(0, 65535));
         end
         repeat (300) begin
            ev = make_random_event();
            send_event(ev, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("udp_session_tracker_unit_tb: done, clean");
      else
         $display("udp_session_tracker_unit_tb: done, errors");
      $finish;
   end

endmodule
